/* rtl/bap_pkg.sv */
// Shared constants, types and arithmetic helpers of the binomial option pricer.
package bap_pkg;

    // Number of tree periods; the cell row holds one cell per leaf.
    localparam int STEPS = 3;
    localparam int CELLS = STEPS + 1;
    localparam int LVL_W = $clog2(STEPS + 1);

    localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(STEPS);
    localparam logic [LVL_W-1:0] LVL_ZERO = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PROBABILITY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISCOUNT = CFG_IDX_W'(3);

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    localparam logic [31:0] UP_FACTOR_RST   = 32'h1000_0000;
    localparam logic [30:0] DOWN_FACTOR_RST = 31'h4000_0000;
    localparam logic [30:0] UP_PROB_RST     = 31'h2000_0000;
    localparam logic [30:0] DISCOUNT_RST    = 31'h4000_0000;

    // Operation that the sequencer broadcasts to every cell.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DCHAIN,
        OP_LOAD,
        OP_SUM,
        OP_UP,
        OP_LEAF,
        OP_DISC
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  iter;
    } ctrl_t;

    // Rounds a Q16.16 times factor product half up and saturates it to 32 bits.
    // Bit 32 of the result is the saturation flag.
    function automatic logic [32:0] round_sat(input logic [63:0] prod, input logic frac28);
        logic [63:0] r;
        logic [32:0] res;
        if (frac28)
            r = (prod + 64'h0000_0000_0800_0000) >> 28;
        else
            r = (prod + 64'h0000_0000_2000_0000) >> 30;
        if (r[63:32] != 32'd0)
            res = {1'b1, MAX32};
        else
            res = {1'b0, r[31:0]};
        return res;
    endfunction

    function automatic logic [31:0] intrinsic(input logic [31:0] price,
                                              input logic [31:0] strike,
                                              input logic        call);
        logic [31:0] res;
        if (call)
            res = (price > strike) ? price - strike : 32'd0;
        else
            res = (strike > price) ? strike - price : 32'd0;
        return res;
    endfunction

endpackage

/* rtl/bap_cell.sv */
// One tree column cell: holds a price chain base, a node price and a node value.
module bap_cell (
    input  logic                     clk,
    input  logic [bap_pkg::LVL_W-1:0] cell_idx,
    input  bap_pkg::ctrl_t           ctrl,
    input  logic [31:0]              up_factor,
    input  logic [30:0]              down_factor,
    input  logic [30:0]              up_prob,
    input  logic [30:0]              down_prob,
    input  logic [30:0]              step_discount,
    input  logic [31:0]              strike,
    input  logic                     is_call,
    input  logic [31:0]              e_in,
    input  logic [31:0]              v_in,
    output logic [31:0]              e_out,
    output logic [31:0]              v_out,
    output logic                     sat
);

    logic [31:0] e_reg;
    logic [31:0] p_reg;
    logic [31:0] v_reg;
    logic [31:0] exp_reg;
    logic [62:0] prod_up_reg;
    logic [62:0] prod_dn_reg;

    logic        active;
    logic        chain_hit;
    logic        is_top;
    logic [31:0] mul_a;
    logic [31:0] mul_f;
    logic        frac28;
    logic [63:0] product;
    logic [32:0] rounded;
    logic        mul_used;
    logic [31:0] ex_value;
    logic [31:0] best;
    logic [63:0] up_term;
    logic [63:0] dn_term;
    logic [63:0] exp_sum;

    assign active    = cell_idx <= ctrl.level;
    assign chain_hit = ({1'b0, cell_idx} + {1'b0, ctrl.iter}) == {1'b0, bap_pkg::LAST_IDX};
    assign is_top    = cell_idx == bap_pkg::LAST_IDX;

    always_comb
    begin
        mul_a    = exp_reg;
        mul_f    = {1'b0, step_discount};
        frac28   = 1'b0;
        mul_used = 1'b0;
        case (ctrl.op)
            bap_pkg::OP_DCHAIN:
            begin
                mul_a    = e_in;
                mul_f    = {1'b0, down_factor};
                mul_used = chain_hit && !is_top;
            end
            bap_pkg::OP_UP:
            begin
                mul_a    = p_reg;
                mul_f    = up_factor;
                frac28   = 1'b1;
                mul_used = active && (cell_idx >= ctrl.iter);
            end
            bap_pkg::OP_DISC:
            begin
                mul_used = active;
            end
            default:
            begin
                mul_used = 1'b0;
            end
        endcase
    end

    assign product  = {32'd0, mul_a} * {32'd0, mul_f};
    assign rounded  = bap_pkg::round_sat(product, frac28);
    assign sat      = mul_used && rounded[32];
    assign ex_value = bap_pkg::intrinsic(p_reg, strike, is_call);
    assign best     = (ex_value > rounded[31:0]) ? ex_value : rounded[31:0];

    // Weighted sum of the upper and lower successor values.
    assign up_term = {33'd0, up_prob} * {32'd0, v_in};
    assign dn_term = {33'd0, down_prob} * {32'd0, v_reg};
    assign exp_sum = {1'b0, prod_up_reg} + {1'b0, prod_dn_reg} + 64'h0000_0000_2000_0000;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            bap_pkg::OP_DCHAIN:
            begin
                // The top cell takes the spot price; each lower cell one more down move.
                if (chain_hit)
                    e_reg <= is_top ? e_in : rounded[31:0];
            end
            bap_pkg::OP_LOAD:
            begin
                p_reg       <= e_reg;
                prod_up_reg <= up_term[62:0];
                prod_dn_reg <= dn_term[62:0];
            end
            bap_pkg::OP_SUM:
            begin
                exp_reg <= exp_sum[61:30];
            end
            bap_pkg::OP_UP:
            begin
                if (mul_used)
                    p_reg <= rounded[31:0];
            end
            bap_pkg::OP_LEAF:
            begin
                v_reg <= ex_value;
                e_reg <= e_in;
            end
            bap_pkg::OP_DISC:
            begin
                if (active)
                    v_reg <= best;
                e_reg <= e_in;
            end
            default:
            begin
            end
        endcase
    end

    assign e_out = e_reg;
    assign v_out = v_reg;

endmodule

/* rtl/bap_seq.sv */
// Sequencer that walks the cell row through price chains and backward induction.
module bap_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           out_free,
    output bap_pkg::ctrl_t ctrl,
    output logic           idle,
    output logic           done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DCHAIN,
        S_LOAD,
        S_SUM,
        S_UP,
        S_FIN,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [bap_pkg::LVL_W-1:0]  level_reg;
    logic [bap_pkg::LVL_W-1:0]  iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            level_reg <= bap_pkg::LAST_IDX;
            iter_reg  <= bap_pkg::LVL_ZERO;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DCHAIN;
                        level_reg <= bap_pkg::LAST_IDX;
                        iter_reg  <= bap_pkg::LVL_ZERO;
                    end
                end
                S_DCHAIN:
                begin
                    if (iter_reg == bap_pkg::LAST_IDX)
                        state_reg <= S_LOAD;
                    else
                        iter_reg <= iter_reg + bap_pkg::LVL_ONE;
                end
                S_LOAD:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    iter_reg <= bap_pkg::LVL_ONE;
                    if (level_reg == bap_pkg::LVL_ZERO)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_UP;
                end
                S_UP:
                begin
                    if (iter_reg == level_reg)
                        state_reg <= S_FIN;
                    else
                        iter_reg <= iter_reg + bap_pkg::LVL_ONE;
                end
                S_FIN:
                begin
                    if (level_reg == bap_pkg::LVL_ZERO)
                        state_reg <= S_DONE;
                    else
                    begin
                        level_reg <= level_reg - bap_pkg::LVL_ONE;
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        ctrl.level = level_reg;
        ctrl.iter  = iter_reg;
        case (state_reg)
            S_DCHAIN: ctrl.op = bap_pkg::OP_DCHAIN;
            S_LOAD:   ctrl.op = bap_pkg::OP_LOAD;
            S_SUM:    ctrl.op = bap_pkg::OP_SUM;
            S_UP:     ctrl.op = bap_pkg::OP_UP;
            S_FIN:    ctrl.op = (level_reg == bap_pkg::LAST_IDX) ? bap_pkg::OP_LEAF
                                                                 : bap_pkg::OP_DISC;
            default:  ctrl.op = bap_pkg::OP_IDLE;
        endcase
    end

    assign idle = state_reg == S_IDLE;
    assign done = state_reg == S_DONE;

endmodule

/* rtl/binomial_american_option_price.sv */
// An accepted option builds the price chains, then walks the levels from leaves to root;
// each level takes a load, a sum, a step per up move and a final step, as each cell's price
// multiplier serves chain, up and discount steps. Input reopens once the result is loaded.
// The final load waits while the previous result is still held in the output register.
// Reset (rst_n low, asynchronous) clears control and loads the configuration defaults;
// the node stores in the cell row are not cleared.
module binomial_american_option_price (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // spot_price, strike_price
    input  logic [0:0]                    s_tuser,  // is_call
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // option_value
    output logic [0:0]                    m_tuser,  // saturated
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic [31:0] up_factor_reg;
    logic [30:0] down_factor_reg;
    logic [30:0] up_prob_reg;
    logic [30:0] discount_reg;

    logic [31:0] spot_reg;
    logic [31:0] strike_reg;
    logic        call_reg;
    logic        sat_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic           in_accept;
    logic           out_free;
    logic           seq_idle;
    logic           seq_done;
    bap_pkg::ctrl_t ctrl;
    logic [30:0]    q_clamped;
    logic [30:0]    q_down;

    logic [31:0]               e_bus [0:bap_pkg::STEPS];
    logic [31:0]               v_bus [0:bap_pkg::STEPS];
    logic [bap_pkg::STEPS:0]   cell_sat;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = seq_idle;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign q_clamped = (up_prob_reg > bap_pkg::Q30_ONE) ? bap_pkg::Q30_ONE : up_prob_reg;
    assign q_down    = bap_pkg::Q30_ONE - q_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= bap_pkg::UP_FACTOR_RST;
            down_factor_reg <= bap_pkg::DOWN_FACTOR_RST;
            up_prob_reg     <= bap_pkg::UP_PROB_RST;
            discount_reg    <= bap_pkg::DISCOUNT_RST;
            sat_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bap_pkg::CFG_UP_FACTOR:      up_factor_reg   <= cfg_data;
                    bap_pkg::CFG_DOWN_FACTOR:    down_factor_reg <= cfg_data[30:0];
                    bap_pkg::CFG_UP_PROBABILITY: up_prob_reg     <= cfg_data[30:0];
                    bap_pkg::CFG_STEP_DISCOUNT:  discount_reg    <= cfg_data[30:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
                sat_reg <= 1'b0;
            else
                sat_reg <= sat_reg || (|cell_sat);

            if (seq_done && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            spot_reg   <= s_tdata[31:0];
            strike_reg <= s_tdata[63:32];
            call_reg   <= s_tuser[0];
        end
        if (seq_done && out_free)
        begin
            m_tdata_reg <= v_bus[0];
            m_tuser_reg <= sat_reg;
        end
    end

    bap_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .out_free (out_free),
        .ctrl     (ctrl),
        .idle     (seq_idle),
        .done     (seq_done)
    );

    for (genvar g = 0; g <= bap_pkg::STEPS; g++)
    begin : g_cell
        logic [31:0] e_next_in;
        logic [31:0] v_next_in;

        if (g == bap_pkg::STEPS)
        begin : g_top
            assign e_next_in = spot_reg;
            assign v_next_in = 32'd0;
        end
        else
        begin : g_mid
            assign e_next_in = e_bus[g+1];
            assign v_next_in = v_bus[g+1];
        end

        bap_cell u_cell (
            .clk           (clk),
            .cell_idx      (bap_pkg::LVL_W'(g)),
            .ctrl          (ctrl),
            .up_factor     (up_factor_reg),
            .down_factor   (down_factor_reg),
            .up_prob       (q_clamped),
            .down_prob     (q_down),
            .step_discount (discount_reg),
            .strike        (strike_reg),
            .is_call       (call_reg),
            .e_in          (e_next_in),
            .v_in          (v_next_in),
            .e_out         (e_bus[g]),
            .v_out         (v_bus[g]),
            .sat           (cell_sat[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/bap_checker.sv */
// Port-level checks for the binomial option pricer and their binding to the top level.
module bap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An accepted option keeps the input side closed while the tree is evaluated.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again right after an accept");

    // A new result only appears at the end of an evaluation, never from idle.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a running evaluation");

    // Once reset has been seen at an edge, no result is pending.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind binomial_american_option_price bap_checker u_bap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/option_checker.sv */
`timescale 1ns / 100ps
// Watches the pricer's channels, predicts each root value and compares it with the block's words.
module option_checker
    import bap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatch_count,
    output int                   open_count
);

    typedef struct packed {
        logic [31:0] option_value;
        logic        saturated;
    } root_t;

    logic [31:0] up_q28;
    logic [30:0] down_q30;
    logic [30:0] prob_q30;
    logic [30:0] disc_q30;

    root_t root_q[$];

    // Multiplies by a factor with frac fraction bits, rounds half up and clips to 32 bits.
    function automatic logic [31:0] scale(input logic [31:0] a, input logic [31:0] f,
                                          input int frac, output logic ovf);
        logic [63:0] p;
        p = (64'(a) * 64'(f) + (64'd1 << (frac - 1))) >> frac;
        ovf = (p[63:32] != 32'd0);
        return ovf ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [31:0] tree_price(input logic [31:0] spot, input int level,
                                               input int ups, inout logic sat);
        logic [31:0] p;
        logic        ovf;
        p = spot;
        for (int k = 0; k < level - ups; k++)
        begin
            p = scale(p, {1'b0, down_q30}, 30, ovf);
            sat |= ovf;
        end
        for (int k = 0; k < ups; k++)
        begin
            p = scale(p, up_q28, 28, ovf);
            sat |= ovf;
        end
        return p;
    endfunction

    function automatic logic [31:0] exercise_value(input logic [31:0] price,
                                                   input logic [31:0] strike, input logic call);
        if (call)
            return (price > strike) ? price - strike : 32'd0;
        return (strike > price) ? strike - price : 32'd0;
    endfunction

    function automatic root_t price_american(input logic [31:0] spot, input logic [31:0] strike,
                                             input logic call);
        logic [31:0] px [CELLS];
        logic [31:0] val [CELLS];
        logic [31:0] q;
        logic [63:0] acc;
        logic [31:0] mean;
        logic [31:0] hold;
        logic [31:0] early;
        logic        sat;
        logic        ovf;
        root_t       r;
        sat = 1'b0;
        // A probability above one is taken as exactly one.
        q = (prob_q30 > Q30_ONE) ? {1'b0, Q30_ONE} : {1'b0, prob_q30};
        for (int j = 0; j <= STEPS; j++)
        begin
            px[j] = tree_price(spot, STEPS, j, sat);
            val[j] = exercise_value(px[j], strike, call);
        end
        for (int i = STEPS - 1; i >= 0; i--)
        begin
            for (int j = 0; j <= i; j++)
                px[j] = tree_price(spot, i, j, sat);
            for (int j = 0; j <= i; j++)
            begin
                acc = 64'(q) * 64'(val[j + 1]) + 64'(32'h4000_0000 - q) * 64'(val[j]);
                mean = 32'((acc + 64'h2000_0000) >> 30);
                hold = scale(mean, {1'b0, disc_q30}, 30, ovf);
                sat |= ovf;
                early = exercise_value(px[j], strike, call);
                val[j] = (early > hold) ? early : hold;
            end
        end
        r.option_value = val[0];
        r.saturated = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        if (mismatch_count < 10)
            $display("%0t: %s expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        root_t want;
        if (!rst_n)
        begin
            up_q28 = UP_FACTOR_RST;
            down_q30 = DOWN_FACTOR_RST;
            prob_q30 = UP_PROB_RST;
            disc_q30 = DISCOUNT_RST;
            root_q.delete();
            mismatch_count = 0;
            open_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_UP_FACTOR:      up_q28 = cfg_data;
                    CFG_DOWN_FACTOR:    down_q30 = cfg_data[30:0];
                    CFG_UP_PROBABILITY: prob_q30 = cfg_data[30:0];
                    CFG_STEP_DISCOUNT:  disc_q30 = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                root_q.push_back(price_american(s_tdata[31:0], s_tdata[63:32], s_tuser[0]));
            if (m_tvalid && m_tready)
            begin
                if (root_q.size() == 0)
                    report("unexpected word, option_value", 32'hx, m_tdata);
                else
                begin
                    want = root_q.pop_front();
                    if (m_tdata !== want.option_value)
                        report("option_value", want.option_value, m_tdata);
                    if (m_tuser[0] !== want.saturated)
                        report("saturated", 32'(want.saturated), 32'(m_tuser[0]));
                end
            end
            open_count <= root_q.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Bench top for the binomial option pricer: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import bap_pkg::*;

    localparam int LATENCY = (STEPS + 1) * (STEPS + 8) / 2 + 1;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 55;
    localparam int DIRECTED = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [63:0]          s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [31:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_ready;
    int                   mismatch_count;
    int                   open_count;

    // No new idle gaps are started on either side while calm is set.
    bit                   calm = 1'b0;
    int                   stall_left = 0;

    logic [31:0] dir_spot   [DIRECTED] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                           32'h0064_0000, 32'h0064_0000};
    logic [31:0] dir_strike [DIRECTED] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                           32'h005F_0000, 32'h0069_0000};
    logic        dir_call   [DIRECTED] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    binomial_american_option_price dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    option_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .open_count     (open_count)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 15);
        return $urandom_range(3);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    // Valid stays high after a word is taken, so back-to-back words need no second assignment.
    task automatic send_option(input logic [31:0] spot, input logic [31:0] strike,
                               input logic call);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {strike, spot};
        s_tuser <= call;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cfg(input logic [31:0] up, input logic [31:0] down,
                            input logic [31:0] prob, input logic [31:0] disc);
        write_reg(CFG_UP_FACTOR, up);
        write_reg(CFG_DOWN_FACTOR, down);
        write_reg(CFG_UP_PROBABILITY, prob);
        write_reg(CFG_STEP_DISCOUNT, disc);
    endtask

    // Lets every expected word arrive, then gives the block time to settle.
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic send_directed();
        for (int n = 0; n < DIRECTED; n++)
            send_option(dir_spot[n], dir_strike[n], dir_call[n]);
    endtask

    task automatic random_cfg();
        logic [31:0] up;
        if ($urandom_range(1) == 0)
        begin
            // Plausible market: down move is the reciprocal of the up move.
            up = 32'h1000_0000 + $urandom_range(32'h0800_0000);
            load_cfg(up, 32'((64'd1 << 58) / 64'(up)),
                     $urandom_range(32'h2CCC_CCCC, 32'h1333_3333),
                     $urandom_range(32'h4000_0000, 32'h3E00_0000));
        end
        else
            load_cfg($urandom_range(32'hFFFF_FFFF, 32'h1000_0000), $urandom(), $urandom(),
                     $urandom());
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(255, 4)), $urandom());
        close_cfg();
    endtask

    task automatic random_option();
        logic [31:0] spot;
        logic [31:0] strike;
        if ($urandom_range(3) != 0)
        begin
            spot = $urandom_range(32'h00C8_0000, 32'h0001_0000);
            strike = $urandom_range(spot + spot / 3, spot - spot / 3);
        end
        else
        begin
            spot = $urandom();
            strike = $urandom();
        end
        send_option(spot, strike, 1'($urandom_range(1)));
    endtask

    initial
    begin
        #5_000_000;
        $display("[binomial_american_option_price] ERROR");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: flat tree, every node sits at the spot price.
        send_directed();
        drain(LATENCY);

        load_cfg(32'h1199_999A, 32'h3A2E_8BA3, 32'h2200_0000, 32'h3F5C_28F6);
        close_cfg();
        send_directed();
        drain(LATENCY);

        // Top extremes with the ignored upper bits set: down and discount near two,
        // probability clamped to one, prices saturating along the chain.
        load_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_W'(4), 32'h0000_0001);
        write_reg(CFG_IDX_W'(255), 32'hFFFF_FFFF);
        close_cfg();
        send_directed();
        send_option(32'h0010_0000, 32'h0000_0000, 1'b1);
        drain(LATENCY);

        load_cfg(32'h1000_0000, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000);
        close_cfg();
        send_directed();
        drain(LATENCY);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm = ($urandom_range(3) == 0);
            random_cfg();
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_option();
            drain(LATENCY);
        end

        drain(2 * LATENCY);
        if (mismatch_count == 0)
            $display("[binomial_american_option_price] OK");
        else
            $display("[binomial_american_option_price] ERROR");
        $finish;
    end

endmodule

/* binomial_american_option_price.f */
rtl/bap_pkg.sv
rtl/bap_cell.sv
rtl/bap_seq.sv
rtl/binomial_american_option_price.sv
rtl/bap_checker.sv
bench/option_checker.sv
bench/testbench.sv
